>>> rtl/rfr_pkg.sv
package rfr_pkg;

  // token and field widths
  localparam int NUM_W      = 32;
  localparam int HEAD_W     = 64;
  localparam int CHAR_W     = 8;
  localparam int SEX_W      = 32;
  localparam int SMALL_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int TEXT_CHARS = 9;

  // sum of two headers, two ids and two 16-bit numbers stays below 2**18
  localparam int SUM_W = 18;

  localparam logic [NUM_W-1:0]      HEADER_TOKEN  = 32'h0000_00FF;
  localparam logic [8:0]            CHECK_MOD     = 9'd255;
  localparam logic [CFG_DATA_W-1:0] SENDER_RESET  = 8'h01;
  localparam logic [CFG_DATA_W-1:0] RECEIVER_RESET = 8'h11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENDER   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVER = 8'd1;

  typedef enum logic [3:0] {
    PH_FF1      = 4'd0,
    PH_FF2      = 4'd1,
    PH_SENDER   = 4'd2,
    PH_RECEIVER = 4'd3,
    PH_NAME     = 4'd4,
    PH_SEX      = 4'd5,
    PH_AGE      = 4'd6,
    PH_INST     = 4'd7,
    PH_CHECK    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number_value;
    logic [HEAD_W-1:0] text_head;
    logic [CHAR_W-1:0] text_tail;
  } token_t;

  typedef struct packed {
    logic [HEAD_W-1:0]  name_head;
    logic [CHAR_W-1:0]  name_tail;
    logic [SEX_W-1:0]   sex_text;
    logic [SMALL_W-1:0] age_value;
    logic [SMALL_W-1:0] institution_value;
    logic               checksum_ok;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_write_t;

endpackage

>>> rtl/rfr_channels.sv
// token input channel
interface rfr_token_if import rfr_pkg::*; ();
  logic   valid;
  logic   ready;
  token_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// frame result channel
interface rfr_result_if import rfr_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// configuration write channel
interface rfr_cfg_if import rfr_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/record_frame_receiver_top.sv
// channel   dir  payload                                           transfer
// tokens    in   number_value, text_head, text_tail                valid & ready
// results   out  name_head, name_tail, sex_text, age_value,        valid & ready
//                institution_value, checksum_ok
// cfg       in   index (0 sender id, 1 receiver id), value         valid & ready
//
// One token per cycle: each token updates the phase and the held fields in the
// cycle it is taken; the check token loads the result register, whose contents
// appear in the next cycle. tokens.ready drops only while a result waits in the
// result register and the sink holds results.ready low. rst (synchronous) sets
// the phase to the first header, clears the sum and the result valid, and
// restores the id registers to 1 and 17. cfg is always ready.
module record_frame_receiver_top import rfr_pkg::*; #(
  parameter int NAME_CHARS = 9,
  parameter int SEX_CHARS  = 4
) (
  input logic          clk,
  input logic          rst,
  rfr_token_if.sink    tokens,
  rfr_result_if.source results,
  rfr_cfg_if.sink      cfg
);

  logic [CFG_DATA_W-1:0] expected_sender;
  logic [CFG_DATA_W-1:0] expected_receiver;

  phase_t             phase;
  phase_t             phase_next;
  logic [SUM_W-1:0]   running_sum;
  logic [SUM_W-1:0]   running_sum_next;
  logic [HEAD_W-1:0]  held_name;
  logic [CHAR_W-1:0]  held_name_last;
  logic [SEX_W-1:0]   held_sex;
  logic [SMALL_W-1:0] held_age;
  logic [SMALL_W-1:0] held_institution;

  logic    out_valid;
  result_t out_data;

  logic               take;
  logic [NUM_W-1:0]   num;
  logic [SUM_W-1:0]   num_small;
  logic [HEAD_W-1:0]  name_clip;
  logic [CHAR_W-1:0]  name_last_clip;
  logic [SEX_W-1:0]   sex_clip;
  logic [9:0]         fold1;
  logic [8:0]         fold2;
  logic [7:0]         residue;
  logic               sum_match;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_sender   <= SENDER_RESET;
      expected_receiver <= RECEIVER_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_SENDER:   expected_sender   <= cfg.data.value;
        REG_RECEIVER: expected_receiver <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // token transfer whenever the result register is free or draining
  assign tokens.ready = !out_valid || results.ready;
  assign take         = tokens.valid && tokens.ready;
  assign num          = tokens.data.number_value;
  assign num_small    = {{(SUM_W-SMALL_W){1'b0}}, num[SMALL_W-1:0]};

  // name text: keep characters up to the first zero and the character limit
  always_comb begin
    logic             live;
    logic [CHAR_W-1:0] c;
    live           = 1'b1;
    name_clip      = '0;
    name_last_clip = '0;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      c    = (i < TEXT_CHARS - 1) ? tokens.data.text_head[CHAR_W*(i%8) +: CHAR_W]
                                  : tokens.data.text_tail;
      live = live && (c != '0) && (i < NAME_CHARS);
      if (live) begin
        if (i < TEXT_CHARS - 1) name_clip[CHAR_W*(i%8) +: CHAR_W] = c;
        else name_last_clip = c;
      end
    end
  end

  // sex text: low four characters only
  always_comb begin
    logic             live;
    logic [CHAR_W-1:0] c;
    live     = 1'b1;
    sex_clip = '0;
    for (int i = 0; i < SEX_W / CHAR_W; i++) begin
      c    = tokens.data.text_head[CHAR_W*i +: CHAR_W];
      live = live && (c != '0) && (i < SEX_CHARS);
      if (live) sex_clip[CHAR_W*i +: CHAR_W] = c;
    end
  end

  // sum mod 255 by folding bytes, since 256 is 1 mod 255
  always_comb begin
    fold1 = {8'd0, running_sum[SUM_W-1:16]} + {2'd0, running_sum[15:8]}
            + {2'd0, running_sum[7:0]};
    fold2 = {7'd0, fold1[9:8]} + {1'b0, fold1[7:0]};
    if (fold2 >= CHECK_MOD) residue = 8'(fold2 - CHECK_MOD);
    else residue = fold2[7:0];
    sum_match = (num == {{(NUM_W-8){1'b0}}, residue});
  end

  // frame phase and running sum
  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    case (phase)
      PH_FF1: begin
        if (num == HEADER_TOKEN) begin
          phase_next       = PH_FF2;
          running_sum_next = running_sum + SUM_W'(HEADER_TOKEN[7:0]);
        end
      end
      PH_FF2: begin
        if (num == HEADER_TOKEN) begin
          phase_next       = PH_SENDER;
          running_sum_next = running_sum + SUM_W'(HEADER_TOKEN[7:0]);
        end
      end
      PH_SENDER: begin
        if (num == {{(NUM_W-CFG_DATA_W){1'b0}}, expected_sender}) begin
          phase_next       = PH_RECEIVER;
          running_sum_next = running_sum + SUM_W'(expected_sender);
        end
      end
      PH_RECEIVER: begin
        if (num == {{(NUM_W-CFG_DATA_W){1'b0}}, expected_receiver}) begin
          phase_next       = PH_NAME;
          running_sum_next = running_sum + SUM_W'(expected_receiver);
        end
      end
      PH_NAME: phase_next = PH_SEX;
      PH_SEX:  phase_next = PH_AGE;
      PH_AGE: begin
        phase_next       = PH_INST;
        running_sum_next = running_sum + num_small;
      end
      PH_INST: begin
        phase_next       = PH_CHECK;
        running_sum_next = running_sum + num_small;
      end
      PH_CHECK: begin
        phase_next       = PH_FF1;
        running_sum_next = '0;
      end
      default: begin
        phase_next       = PH_FF1;
        running_sum_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_FF1;
      running_sum <= '0;
    end else if (take) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
    end
  end

  // held frame fields
  always_ff @(posedge clk) begin
    if (take) begin
      case (phase)
        PH_NAME: begin
          held_name      <= name_clip;
          held_name_last <= name_last_clip;
        end
        PH_SEX:  held_sex         <= sex_clip;
        PH_AGE:  held_age         <= num[SMALL_W-1:0];
        PH_INST: held_institution <= num[SMALL_W-1:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && phase == PH_CHECK) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && phase == PH_CHECK) begin
      out_data.name_head         <= held_name;
      out_data.name_tail         <= held_name_last;
      out_data.sex_text          <= held_sex;
      out_data.age_value         <= held_age;
      out_data.institution_value <= held_institution;
      out_data.checksum_ok       <= sum_match;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

>>> sim/record_frame_receiver_top_test.sv
module record_frame_receiver_top_test;
  import rfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hA5;

  logic clk;
  logic rst;

  rfr_token_if  tok_ch();
  rfr_result_if res_ch();
  rfr_cfg_if    cfg_ch();

  record_frame_receiver_top u_dut (
    .clk(clk),
    .rst(rst),
    .tokens(tok_ch),
    .results(res_ch),
    .cfg(cfg_ch)
  );

  // tokens waiting to be driven and records waiting to come out
  token_t  token_backlog[$];
  result_t pending_records[$];

  int tokens_queued;
  int tokens_taken;
  int cfg_writes;
  int fail_count;
  int cycles;
  bit token_taken;
  bit steady;

  // id values as the stimulus side sees them
  logic [7:0] gen_sender;
  logic [7:0] gen_receiver;

  // parser copy used for prediction
  phase_t      parse_phase;
  logic [19:0] frame_sum;
  logic [63:0] kept_name;
  logic [7:0]  kept_name_last;
  logic [31:0] kept_sex;
  logic [15:0] kept_age;
  logic [15:0] kept_inst;
  logic [7:0]  want_sender;
  logic [7:0]  want_receiver;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_failure(string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // keep characters below the limit, up to the first zero; returns {tail, head}
  function automatic logic [71:0] clip_chars(logic [63:0] head, logic [7:0] tail, int limit);
    logic [71:0] chars;
    logic [71:0] kept;
    bit live;
    chars = {tail, head};
    kept = '0;
    live = 1'b1;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      if (i >= limit || chars[8*i +: 8] == 8'h00) live = 1'b0;
      if (live) kept[8*i +: 8] = chars[8*i +: 8];
    end
    return kept;
  endfunction

  // parser prediction for one accepted token
  function automatic void advance_parser(token_t t);
    logic [71:0] clipped;
    result_t rec;
    case (parse_phase)
      PH_FF1: begin
        if (t.number_value == HEADER_TOKEN) begin
          frame_sum = frame_sum + 20'(t.number_value);
          parse_phase = PH_FF2;
        end
      end
      PH_FF2: begin
        if (t.number_value == HEADER_TOKEN) begin
          frame_sum = frame_sum + 20'(t.number_value);
          parse_phase = PH_SENDER;
        end
      end
      PH_SENDER: begin
        if (t.number_value == {24'h0, want_sender}) begin
          frame_sum = frame_sum + 20'(want_sender);
          parse_phase = PH_RECEIVER;
        end
      end
      PH_RECEIVER: begin
        if (t.number_value == {24'h0, want_receiver}) begin
          frame_sum = frame_sum + 20'(want_receiver);
          parse_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        clipped = clip_chars(t.text_head, t.text_tail, 9);
        kept_name = clipped[63:0];
        kept_name_last = clipped[71:64];
        parse_phase = PH_SEX;
      end
      PH_SEX: begin
        clipped = clip_chars({32'h0, t.text_head[31:0]}, 8'h00, 4);
        kept_sex = clipped[31:0];
        parse_phase = PH_AGE;
      end
      PH_AGE: begin
        kept_age = t.number_value[15:0];
        frame_sum = frame_sum + 20'(kept_age);
        parse_phase = PH_INST;
      end
      PH_INST: begin
        kept_inst = t.number_value[15:0];
        frame_sum = frame_sum + 20'(kept_inst);
        parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        rec.name_head = kept_name;
        rec.name_tail = kept_name_last;
        rec.sex_text = kept_sex;
        rec.age_value = kept_age;
        rec.institution_value = kept_inst;
        rec.checksum_ok = (t.number_value == 32'(frame_sum % 20'd255));
        pending_records.push_back(rec);
        parse_phase = PH_FF1;
        frame_sum = '0;
      end
      default: begin
        parse_phase = PH_FF1;
        frame_sum = '0;
      end
    endcase
  endfunction

  // compare one record with the oldest prediction
  task automatic check_record(result_t got);
    result_t want;
    if (pending_records.size() == 0) begin
      note_failure($sformatf("record with none pending: %h", got));
    end else begin
      want = pending_records.pop_front();
      if (got.name_head !== want.name_head)
        note_failure($sformatf("name_head %h, want %h", got.name_head, want.name_head));
      if (got.name_tail !== want.name_tail)
        note_failure($sformatf("name_tail %h, want %h", got.name_tail, want.name_tail));
      if (got.sex_text !== want.sex_text)
        note_failure($sformatf("sex_text %h, want %h", got.sex_text, want.sex_text));
      if (got.age_value !== want.age_value)
        note_failure($sformatf("age_value %h, want %h", got.age_value, want.age_value));
      if (got.institution_value !== want.institution_value)
        note_failure($sformatf("institution_value %h, want %h",
                               got.institution_value, want.institution_value));
      if (got.checksum_ok !== want.checksum_ok)
        note_failure($sformatf("checksum_ok %b, want %b", got.checksum_ok, want.checksum_ok));
    end
  endtask

  // monitor: sample every transfer at the rising edge
  always @(posedge clk) begin
    token_taken = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) check_record(res_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_SENDER:   want_sender = cfg_ch.data.value;
          REG_RECEIVER: want_receiver = cfg_ch.data.value;
          default: ;
        endcase
        cfg_writes++;
      end
      if (tok_ch.valid && tok_ch.ready) begin
        advance_parser(tok_ch.data);
        token_taken = 1'b1;
        tokens_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // token driver and result back-pressure, both at the falling edge
  always @(negedge clk) begin
    if (!rst && (!tok_ch.valid || token_taken)) begin
      if (token_backlog.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
        tok_ch.data <= token_backlog.pop_front();
        tok_ch.valid <= 1'b1;
      end else begin
        tok_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= !rst && (steady || $urandom_range(99) >= 9);
  end

  task automatic push_token(logic [31:0] num, logic [63:0] head, logic [7:0] tail);
    token_t t;
    t.number_value = num;
    t.text_head = head;
    t.text_tail = tail;
    token_backlog.push_back(t);
    tokens_queued++;
  endtask

  // wait until every token is taken and every record is out, then let it settle
  task automatic wait_idle();
    while (tokens_taken != tokens_queued || pending_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    int seen;
    seen = cfg_writes;
    cfg_ch.data.index = idx;
    cfg_ch.data.value = val;
    cfg_ch.valid = 1'b1;
    while (cfg_writes == seen) @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_SENDER) gen_sender = val;
    if (idx == REG_RECEIVER) gen_receiver = val;
  endtask

  function automatic logic [63:0] rand_text();
    logic [63:0] h;
    h = {$urandom, $urandom};
    if ($urandom_range(99) < 40) h[8*$urandom_range(7) +: 8] = 8'h00;
    return h;
  endfunction

  function automatic logic [31:0] rand_number();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(120);
    if (r < 75) return $urandom;
    if (r < 85) return 32'h0000_FFFF;
    if (r < 90) return 32'h0001_0000;
    return 32'h0;
  endfunction

  // one frame with random content, sometimes broken or cut short
  task automatic queue_frame();
    int mode;
    int keep;
    int chk;
    logic [31:0] age;
    logic [31:0] inst;
    logic [31:0] check;
    mode = $urandom_range(99);
    keep = (mode < 8) ? $urandom_range(8, 1) : 9;
    age = rand_number();
    inst = rand_number();
    chk = (510 + gen_sender + gen_receiver + age[15:0] + inst[15:0]) % 255;
    case ($urandom_range(3))
      0: check = $urandom;
      1: check = chk + 255;
      default: check = chk;
    endcase
    if ($urandom_range(99) < 75) check = chk;
    // noise ahead of the header
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(3, 1)) push_token($urandom, {$urandom, $urandom}, 8'($urandom));
    for (int step = 0; step < keep; step++) begin
      case (step)
        0, 1: push_token(HEADER_TOKEN, {$urandom, $urandom}, 8'($urandom));
        2: begin
          if (mode >= 8 && mode < 14)
            push_token({24'h0, gen_sender} ^ (32'd1 << $urandom_range(31)), rand_text(),
                       8'($urandom));
          push_token({24'h0, gen_sender}, {$urandom, $urandom}, 8'($urandom));
        end
        3: begin
          if (mode >= 14 && mode < 20)
            push_token({24'h0, gen_receiver} ^ (32'd1 << $urandom_range(31)), rand_text(),
                       8'($urandom));
          push_token({24'h0, gen_receiver}, {$urandom, $urandom}, 8'($urandom));
        end
        4: push_token($urandom, rand_text(), ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom));
        5: push_token($urandom, rand_text(), 8'($urandom));
        6: push_token(age, {$urandom, $urandom}, 8'($urandom));
        7: push_token(inst, {$urandom, $urandom}, 8'($urandom));
        default: push_token(check, {$urandom, $urandom}, 8'($urandom));
      endcase
    end
  endtask

  task automatic run_frames(int count);
    int target;
    target = tokens_queued + count;
    while (tokens_queued < target) queue_frame();
    wait_idle();
  endtask

  initial begin
    int chk;
    clk = 1'b0;
    rst = 1'b1;
    tok_ch.valid = 1'b0;
    tok_ch.data = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    steady = 1'b0;
    gen_sender = SENDER_RESET;
    gen_receiver = RECEIVER_RESET;
    parse_phase = PH_FF1;
    frame_sum = '0;
    kept_name = '0;
    kept_name_last = '0;
    kept_sex = '0;
    kept_age = '0;
    kept_inst = '0;
    want_sender = SENDER_RESET;
    want_receiver = RECEIVER_RESET;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // full frame: noise, upper-bit id mismatch, full-length texts, wide numbers
    push_token(32'h1234_5678, '1, '1);
    push_token(HEADER_TOKEN, 64'h0, 8'h0);
    push_token(32'h0, '1, '1);
    push_token(HEADER_TOKEN, '1, '1);
    push_token(32'h0000_0101, 64'h0, 8'h0);
    push_token(32'hFFFF_FFFF, 64'h0, 8'h0);
    push_token(32'h1, 64'h0, 8'h0);
    push_token(32'd17, 64'h0, 8'h0);
    push_token(32'h0, 64'h0807_0605_0403_0201, 8'h09);
    push_token('1, 64'hFFFF_FFFF_4443_4241, 8'hFF);
    push_token(32'hFFFF_FFFF, '1, '1);
    push_token(32'h0001_2345, 64'h0, 8'h0);
    chk = (510 + 1 + 17 + 16'hFFFF + 16'h2345) % 255;
    push_token(32'(chk), 64'h0, 8'h0);
    // texts cut by a zero character, zero numbers, wrong check
    push_token(HEADER_TOKEN, 64'h0, 8'h0);
    push_token(HEADER_TOKEN, 64'h0, 8'h0);
    push_token(32'h1, 64'h0, 8'h0);
    push_token(32'd17, 64'h0, 8'h0);
    push_token(32'h0, 64'h4142_0043_4445_4647, 8'h48);
    push_token(32'h0, 64'h5555_5555_0000_0046, 8'h00);
    push_token(32'h0, 64'h0, 8'h0);
    push_token(32'h0, 64'h0, 8'h0);
    push_token('1, 64'h0, 8'h0);
    wait_idle();

    // extreme ids
    write_reg(REG_SENDER, 8'h00);
    write_reg(REG_RECEIVER, 8'hFF);
    run_frames(190);

    // opposite extremes, no idling on either side
    write_reg(REG_SENDER, 8'hFF);
    write_reg(REG_RECEIVER, 8'h00);
    steady = 1'b1;
    run_frames(190);
    steady = 1'b0;

    // random ids, sender paused halfway until all records are out
    write_reg(REG_SENDER, 8'($urandom));
    write_reg(REG_RECEIVER, 8'($urandom));
    run_frames(95);
    run_frames(95);

    // unknown index is ignored
    write_reg(REG_UNUSED, 8'($urandom));
    write_reg(REG_SENDER, 8'($urandom));
    write_reg(REG_RECEIVER, 8'($urandom));
    run_frames(190);

    if (pending_records.size() != 0)
      note_failure($sformatf("%0d records never arrived", pending_records.size()));
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rfr_pkg.sv
rtl/rfr_channels.sv
rtl/record_frame_receiver_top.sv
sim/record_frame_receiver_top_test.sv
